// ===== rtl/wrhp_pkg.sv =====
`default_nettype none
package wrhp_pkg;

   // Width of the byte counter; it saturates at its all-ones value.
   localparam int COUNT_BITS = 32;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_SHORT    = 3'd1;
   localparam logic [2:0] STATUS_BAD_TAG  = 3'd2;
   localparam logic [2:0] STATUS_BAD_FMT  = 3'd3;
   localparam logic [2:0] STATUS_NO_DATA  = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] pcm_offset;
      logic [31:0] pcm_length;
      logic [31:0] rate_hz;
      logic [1:0]  channel_count;
      logic [4:0]  sample_width;
   } rsp_payload_type;

   // Input register contents handed to the parser.
   typedef struct packed {
      logic            valid;
      req_payload_type data;
   } stage_type;

   // Format fields gathered from a fmt chunk body.
   typedef struct packed {
      logic        bps16;
      logic [15:0] ch;
      logic        fmt1;
      logic [31:0] rate;
   } fmt_type;

endpackage
`default_nettype wire

// ===== rtl/wav_riff_header_parser.sv =====
// A result is registered in the response register after the parser takes the last byte from
// the input register. Throughput: one byte per cycle; a byte is held there while the
// parser state and the result register update, and only a waiting result blocks a final byte.
// Reset is synchronous and active high; it clears all parser state and the valid flags of
// both register stages, and the parser also returns to that state after each final byte.
`default_nettype none
module wav_riff_header_parser
   import wrhp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   stage_type       stage;
   logic            advance;
   logic            res_valid;
   rsp_payload_type res;

   // A final byte waits while the previous result has not been taken.
   assign advance = stage.valid &&
                    !(stage.data.is_final && rsp_valid && !rsp_ready);

   wrhp_byte_stage u_byte_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .stage     (stage)
   );

   wrhp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   wrhp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/wrhp_byte_stage.sv =====
`default_nettype none
module wrhp_byte_stage
   import wrhp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   input  wire logic            advance,
   output stage_type            stage
);

   logic            valid_ff;
   req_payload_type data_ff;

   assign req_ready = !valid_ff || advance;
   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wrhp_parser.sv =====
`default_nettype none
module wrhp_parser
   import wrhp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire stage_type stage,
   input  wire logic      advance,
   output logic           res_valid,
   output rsp_payload_type res
);

   localparam logic [1:0] PH_TAGS = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_PAD  = 2'd3;

   localparam logic [31:0] TagRiff = 32'h52494646;
   localparam logic [31:0] TagWave = 32'h57415645;
   localparam logic [31:0] TagFmt  = 32'h666D7420;
   localparam logic [31:0] TagData = 32'h64617461;
   localparam logic [31:0] MinFileLen = 32'd44;
   localparam logic [31:0] FmtMinLen  = 32'd16;
   localparam logic [31:0] ChunkStart = 32'd12;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [1:0]  parse_phase_ff, parse_phase_in;
   logic [2:0]  header_pos_ff, header_pos_in;
   logic        tags_good_ff, tags_good_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_len_ff, chunk_len_in;
   logic [31:0] body_left_ff, body_left_in;
   fmt_type     pending_fmt_ff, pending_fmt_in;
   fmt_type     saved_fmt_ff, saved_fmt_in;
   logic [31:0] saved_off_ff, saved_off_in;
   logic [31:0] saved_len_ff, saved_len_in;
   logic        pcm_found_ff, pcm_found_in;

   logic [31:0] idx;
   logic [31:0] total;
   logic [31:0] pos;
   logic [7:0]  b;
   logic [7:0]  tag_byte_riff;
   logic [7:0]  tag_byte_wave;
   logic        commit;
   logic [2:0]  status;

   assign b   = stage.data.in_byte;
   assign idx = 32'(byte_count_ff);
   assign pos = chunk_len_ff - body_left_ff;
   assign tag_byte_riff = TagRiff[(5'd24 - {idx[1:0], 3'b000}) +: 8];
   assign tag_byte_wave = TagWave[(5'd24 - {idx[1:0], 3'b000}) +: 8];

   always_comb begin
      byte_count_in  = byte_count_ff;
      parse_phase_in = parse_phase_ff;
      header_pos_in  = header_pos_ff;
      tags_good_in   = tags_good_ff;
      chunk_tag_in   = chunk_tag_ff;
      chunk_len_in   = chunk_len_ff;
      body_left_in   = body_left_ff;
      pending_fmt_in = pending_fmt_ff;
      saved_fmt_in   = saved_fmt_ff;
      saved_off_in   = saved_off_ff;
      saved_len_in   = saved_len_ff;
      pcm_found_in   = pcm_found_ff;
      commit         = 1'b0;
      status         = STATUS_OK;
      res            = '0;
      res_valid      = 1'b0;

      if (byte_count_ff == CountMax) begin
         total = idx;
      end else begin
         total = idx + 32'd1;
      end

      if (advance) begin
         byte_count_in = (byte_count_ff == CountMax) ? byte_count_ff
                                                      : byte_count_ff + COUNT_BITS'(1);
         case (parse_phase_ff)
            PH_TAGS: begin
               if (idx < 32'd4) begin
                  if (tag_byte_riff != b) tags_good_in = 1'b0;
               end else if (idx >= 32'd8 && idx < ChunkStart) begin
                  if (tag_byte_wave != b) tags_good_in = 1'b0;
               end
               if (idx + 32'd1 >= ChunkStart) begin
                  parse_phase_in = PH_HEAD;
                  header_pos_in  = 3'd0;
               end
            end
            PH_HEAD: begin
               if (!header_pos_ff[2]) begin
                  chunk_tag_in = {chunk_tag_ff[23:0], b};
               end else begin
                  chunk_len_in = {b, chunk_len_ff[31:8]};
               end
               header_pos_in = header_pos_ff + 3'd1;
               if (header_pos_ff == 3'd7) begin
                  pending_fmt_in = '0;
                  body_left_in   = chunk_len_in;
                  if (chunk_len_in == 32'd0) begin
                     commit = 1'b1;
                  end else begin
                     parse_phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               case (pos)
                  32'd0:  if (b == 8'd1) pending_fmt_in.fmt1 = 1'b1;
                  32'd1:  if (b != 8'd0) pending_fmt_in.fmt1 = 1'b0;
                  32'd2:  pending_fmt_in.ch[7:0]    = pending_fmt_ff.ch[7:0] | b;
                  32'd3:  pending_fmt_in.ch[15:8]   = pending_fmt_ff.ch[15:8] | b;
                  32'd4:  pending_fmt_in.rate[7:0]  = pending_fmt_ff.rate[7:0] | b;
                  32'd5:  pending_fmt_in.rate[15:8] = pending_fmt_ff.rate[15:8] | b;
                  32'd6:  pending_fmt_in.rate[23:16] = pending_fmt_ff.rate[23:16] | b;
                  32'd7:  pending_fmt_in.rate[31:24] = pending_fmt_ff.rate[31:24] | b;
                  32'd14: if (b == 8'd16) pending_fmt_in.bps16 = 1'b1;
                  32'd15: if (b != 8'd0) pending_fmt_in.bps16 = 1'b0;
                  default: ;
               endcase
               body_left_in = body_left_ff - 32'd1;
               if (body_left_in == 32'd0) begin
                  commit = 1'b1;
               end
            end
            default: begin
               parse_phase_in = PH_HEAD;
               header_pos_in  = 3'd0;
            end
         endcase

         // A finished chunk updates the saved format or data location.
         if (commit) begin
            parse_phase_in = chunk_len_in[0] ? PH_PAD : PH_HEAD;
            header_pos_in  = 3'd0;
            if (chunk_tag_in == TagFmt && chunk_len_in >= FmtMinLen) begin
               saved_fmt_in = pending_fmt_in;
            end else if (chunk_tag_in == TagData) begin
               saved_off_in = idx + 32'd1 - chunk_len_in;
               saved_len_in = chunk_len_in;
               pcm_found_in = 1'b1;
            end
         end

         if (stage.data.is_final) begin
            if (total < MinFileLen) begin
               status = STATUS_SHORT;
            end else if (!tags_good_in) begin
               status = STATUS_BAD_TAG;
            end else if (!saved_fmt_in.fmt1 || saved_fmt_in.rate == 32'd0 ||
                         saved_fmt_in.ch == 16'd0 || saved_fmt_in.ch > 16'd2 ||
                         !saved_fmt_in.bps16) begin
               status = STATUS_BAD_FMT;
            end else if (!pcm_found_in || saved_len_in == 32'd0) begin
               status = STATUS_NO_DATA;
            end else begin
               status = STATUS_OK;
            end
            res_valid  = 1'b1;
            res.status = status;
            if (status == STATUS_OK) begin
               res.pcm_offset    = saved_off_in;
               res.pcm_length    = saved_len_in;
               res.rate_hz       = saved_fmt_in.rate;
               res.channel_count = saved_fmt_in.ch[1:0];
               res.sample_width  = 5'd16;
            end
            // The next byte starts a new file.
            byte_count_in  = '0;
            parse_phase_in = PH_TAGS;
            header_pos_in  = 3'd0;
            tags_good_in   = 1'b1;
            chunk_tag_in   = '0;
            chunk_len_in   = '0;
            body_left_in   = '0;
            pending_fmt_in = '0;
            saved_fmt_in   = '0;
            saved_off_in   = '0;
            saved_len_in   = '0;
            pcm_found_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         parse_phase_ff <= PH_TAGS;
         header_pos_ff  <= 3'd0;
         tags_good_ff   <= 1'b1;
         chunk_tag_ff   <= '0;
         chunk_len_ff   <= '0;
         body_left_ff   <= '0;
         pending_fmt_ff <= '0;
         saved_fmt_ff   <= '0;
         saved_off_ff   <= '0;
         saved_len_ff   <= '0;
         pcm_found_ff   <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         parse_phase_ff <= parse_phase_in;
         header_pos_ff  <= header_pos_in;
         tags_good_ff   <= tags_good_in;
         chunk_tag_ff   <= chunk_tag_in;
         chunk_len_ff   <= chunk_len_in;
         body_left_ff   <= body_left_in;
         pending_fmt_ff <= pending_fmt_in;
         saved_fmt_ff   <= saved_fmt_in;
         saved_off_ff   <= saved_off_in;
         saved_len_ff   <= saved_len_in;
         pcm_found_ff   <= pcm_found_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wrhp_rsp_reg.sv =====
`default_nettype none
module wrhp_rsp_reg
   import wrhp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            res_valid,
   input  wire rsp_payload_type res,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   logic            valid_ff;
   rsp_payload_type data_ff;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wrhp_pkg::*;

   localparam bit [31:0] TAG_RIFF = "RIFF";
   localparam bit [31:0] TAG_WAVE = "WAVE";
   localparam bit [31:0] TAG_FMT = "fmt ";
   localparam bit [31:0] TAG_DATA = "data";
   localparam int MIN_FILE_BYTES = 44;
   localparam int FMT_MIN_BYTES = 16;
   localparam int FIRST_CHUNK = 12;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_BYTES = 620;
   localparam int RANDOM_FILES = 16;

   typedef enum logic [1:0] {PH_TAGS, PH_HEAD, PH_BODY, PH_PAD} parse_phase_type;

   typedef struct {
      bit [31:0] rate;
      bit        fmt1;
      bit [15:0] ch;
      bit        bps16;
   } fmt_fields_type;

   class wav_header_checker;
      rsp_payload_type expected_summaries[$];
      int              mismatch_count;
      bit [31:0]       byte_count;
      parse_phase_type phase;
      bit [2:0]        head_pos;
      bit              tags_good;
      bit [31:0]       chunk_tag;
      bit [31:0]       chunk_len;
      bit [31:0]       body_left;
      fmt_fields_type  pending_fmt;
      fmt_fields_type  saved_fmt;
      bit [31:0]       pcm_offset;
      bit [31:0]       pcm_length;
      bit              pcm_found;

      function new();
         mismatch_count = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         byte_count = '0;
         phase = PH_TAGS;
         head_pos = '0;
         tags_good = 1'b1;
         chunk_tag = '0;
         chunk_len = '0;
         body_left = '0;
         pending_fmt = '{default: 0};
         saved_fmt = '{default: 0};
         pcm_offset = '0;
         pcm_length = '0;
         pcm_found = 1'b0;
      endfunction

      // A chunk takes effect only once its last byte (idx) has arrived.
      function void commit_chunk(bit [31:0] idx);
         if (chunk_tag == TAG_FMT && chunk_len >= FMT_MIN_BYTES) begin
            saved_fmt = pending_fmt;
         end else if (chunk_tag == TAG_DATA) begin
            pcm_offset = idx + 32'd1 - chunk_len;
            pcm_length = chunk_len;
            pcm_found = 1'b1;
         end
      endfunction

      function void close_body();
         phase = chunk_len[0] ? PH_PAD : PH_HEAD;
         head_pos = '0;
      endfunction

      function void parse_byte(bit [31:0] idx, bit [7:0] b);
         bit [31:0] pos;
         case (phase)
            PH_TAGS: begin
               if (idx < 4) begin
                  if (TAG_RIFF[8 * (3 - idx) +: 8] != b) tags_good = 1'b0;
               end else if (idx >= 8 && idx < 12) begin
                  if (TAG_WAVE[8 * (11 - idx) +: 8] != b) tags_good = 1'b0;
               end
               if (idx + 32'd1 >= FIRST_CHUNK) begin
                  phase = PH_HEAD;
                  head_pos = '0;
               end
            end
            PH_HEAD: begin
               if (head_pos < 4) chunk_tag = {chunk_tag[23:0], b};
               else chunk_len = {b, chunk_len[31:8]};
               head_pos = head_pos + 3'd1;
               if (head_pos == 0) begin
                  pending_fmt = '{default: 0};
                  body_left = chunk_len;
                  if (chunk_len == 0) begin
                     commit_chunk(idx);
                     close_body();
                  end else begin
                     phase = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               pos = chunk_len - body_left;
               if (pos == 0) begin
                  if (b == 8'd1) pending_fmt.fmt1 = 1'b1;
               end else if (pos == 1) begin
                  if (b != 8'd0) pending_fmt.fmt1 = 1'b0;
               end else if (pos == 2) begin
                  pending_fmt.ch[7:0] = b;
               end else if (pos == 3) begin
                  pending_fmt.ch[15:8] = b;
               end else if (pos >= 4 && pos < 8) begin
                  pending_fmt.rate[8 * (pos - 4) +: 8] = b;
               end else if (pos == 14) begin
                  if (b == 8'd16) pending_fmt.bps16 = 1'b1;
               end else if (pos == 15) begin
                  if (b != 8'd0) pending_fmt.bps16 = 1'b0;
               end
               body_left = body_left - 32'd1;
               if (body_left == 0) begin
                  commit_chunk(idx);
                  close_body();
               end
            end
            default: begin
               phase = PH_HEAD;
               head_pos = '0;
            end
         endcase
      endfunction

      function void note_byte(req_payload_type r);
         bit [31:0]       idx;
         bit              fmt_good;
         rsp_payload_type summary;
         idx = byte_count;
         parse_byte(idx, r.in_byte);
         byte_count = (idx == '1) ? idx : idx + 32'd1;
         if (!r.is_final) return;
         fmt_good = saved_fmt.fmt1 && saved_fmt.rate != 0 && saved_fmt.ch != 0 &&
                    saved_fmt.ch <= 2 && saved_fmt.bps16;
         summary = '0;
         if (byte_count < MIN_FILE_BYTES) begin
            summary.status = STATUS_SHORT;
         end else if (!tags_good) begin
            summary.status = STATUS_BAD_TAG;
         end else if (!fmt_good) begin
            summary.status = STATUS_BAD_FMT;
         end else if (!pcm_found || pcm_length == 0) begin
            summary.status = STATUS_NO_DATA;
         end else begin
            summary.status = STATUS_OK;
            summary.pcm_offset = pcm_offset;
            summary.pcm_length = pcm_length;
            summary.rate_hz = saved_fmt.rate;
            summary.channel_count = saved_fmt.ch[1:0];
            summary.sample_width = 5'd16;
         end
         expected_summaries.push_back(summary);
         clear_parser();
      endfunction

      function void check_summary(rsp_payload_type got);
         rsp_payload_type want;
         bit              bad;
         if (expected_summaries.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
               $display("unexpected summary: status %0d offset %0d length %0d",
                        got.status, got.pcm_offset, got.pcm_length);
            return;
         end
         want = expected_summaries.pop_front();
         bad = (got.status !== want.status) || (got.pcm_offset !== want.pcm_offset) ||
               (got.pcm_length !== want.pcm_length) || (got.rate_hz !== want.rate_hz) ||
               (got.channel_count !== want.channel_count) ||
               (got.sample_width !== want.sample_width);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES) begin
               $display("summary mismatch at %0t: expected status %0d offset %0d length %0d",
                        $realtime, want.status, want.pcm_offset, want.pcm_length);
               $display("   rate %0d ch %0d width %0d; got status %0d offset %0d length %0d",
                        want.rate_hz, want.channel_count, want.sample_width,
                        got.status, got.pcm_offset, got.pcm_length);
               $display("   rate %0d ch %0d width %0d",
                        got.rate_hz, got.channel_count, got.sample_width);
            end
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   bit        calm = 1'b0;
   bit        hold_request = 1'b0;
   bit [7:0]  wav_bytes[$];
   int        bytes_sent = 0;
   int        files_sent = 0;

   wav_header_checker summary_board = new();

   wav_riff_header_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) summary_board.note_byte(req_data);
         if (rsp_valid && rsp_ready) summary_board.check_summary(rsp_data);
      end
   end

   // Result side: random stalls, a calm stretch, and one long hold-off on request.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 10);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void add_tag(bit [31:0] tag);
      for (int i = 3; i >= 0; i--) wav_bytes.push_back(tag[8 * i +: 8]);
   endfunction

   function automatic void add_le32(bit [31:0] value);
      for (int i = 0; i < 4; i++) wav_bytes.push_back(value[8 * i +: 8]);
   endfunction

   function automatic void add_header();
      add_tag(TAG_RIFF);
      add_le32($urandom);
      add_tag(TAG_WAVE);
   endfunction

   function automatic void add_chunk_head(bit [31:0] tag, bit [31:0] len);
      add_tag(tag);
      add_le32(len);
   endfunction

   // Full chunk with random body and the pad byte after an odd length.
   function automatic void add_chunk(bit [31:0] tag, int len);
      add_chunk_head(tag, len);
      repeat (len) wav_bytes.push_back($urandom);
      if (len % 2 == 1) wav_bytes.push_back($urandom);
   endfunction

   function automatic void add_fmt(int len, bit [15:0] code, bit [15:0] chans,
                                   bit [31:0] rate, bit [15:0] bits);
      bit [127:0] image;
      image = {bits, 16'($urandom), 32'($urandom), rate, chans, code};
      add_chunk_head(TAG_FMT, len);
      for (int i = 0; i < len; i++)
         wav_bytes.push_back(i < 16 ? image[8 * i +: 8] : 8'($urandom));
      if (len % 2 == 1) wav_bytes.push_back($urandom);
   endfunction

   function automatic void add_random_fmt();
      bit [15:0] code;
      bit [15:0] chans;
      bit [15:0] bits;
      int        len;
      case ($urandom_range(9))
         0: code = $urandom_range(0, 3);
         1: code = $urandom;
         default: code = 16'd1;
      endcase
      case ($urandom_range(9))
         0: chans = $urandom_range(0, 3);
         1: chans = $urandom;
         default: chans = $urandom_range(1, 2);
      endcase
      case ($urandom_range(9))
         0: bits = 16'd8;
         1: bits = $urandom;
         default: bits = 16'd16;
      endcase
      case ($urandom_range(9))
         0: len = $urandom_range(0, 15);
         1: len = $urandom_range(17, 30);
         default: len = 16;
      endcase
      add_fmt(len, code, chans, ($urandom_range(19) == 0) ? 32'd0 : $urandom, bits);
   endfunction

   function automatic void add_random_data();
      case ($urandom_range(9))
         0: add_chunk(TAG_DATA, 0);
         1: add_chunk(TAG_DATA, $urandom_range(41, 150));
         default: add_chunk(TAG_DATA, $urandom_range(1, 40));
      endcase
   endfunction

   // Mostly well-formed files with random content; some noise, bad tags and cut-offs.
   function automatic void random_file();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 70)) wav_bytes.push_back($urandom);
         return;
      end
      add_header();
      if ($urandom_range(99) < 6)
         wav_bytes[($urandom_range(1) ? 0 : 8) + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(3) == 0) add_chunk($urandom, $urandom_range(0, 12));
      if ($urandom_range(9) != 0) add_random_fmt();
      if ($urandom_range(3) == 0) add_chunk($urandom, $urandom_range(0, 12));
      if ($urandom_range(9) != 0) add_random_data();
      if ($urandom_range(5) == 0) begin
         if ($urandom_range(1)) add_random_fmt();
         else add_random_data();
      end
      if ($urandom_range(4) == 0) add_chunk($urandom, $urandom_range(0, 12));
      if ($urandom_range(9) == 0)
         wav_bytes = wav_bytes[0:$urandom_range(0, wav_bytes.size() - 1)];
   endfunction

   task automatic send_byte(bit [7:0] b, bit fin);
      req_data <= '{in_byte: b, is_final: fin};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_file();
      int last;
      last = wav_bytes.size() - 1;
      for (int i = 0; i <= last; i++) send_byte(wav_bytes[i], i == last);
      bytes_sent += last + 1;
      files_sent++;
      wav_bytes.delete();
   endtask

   // The sender stops offering until every outstanding summary has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (summary_board.expected_summaries.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int first_bytes;
      int first_files;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Well-formed mono file, then stereo with pads, odd chunks and an empty chunk.
      add_header(); add_fmt(16, 1, 1, 8000, 16); add_chunk(TAG_DATA, 4); send_file();
      add_header(); add_fmt(18, 1, 2, 32'hFFFF_FFFF, 16); add_chunk("LIST", 3);
      add_chunk(TAG_DATA, 5); add_chunk($urandom, 0); send_file();
      // Too short: a single byte, and a good file cut to one byte below the minimum.
      wav_bytes.push_back(8'h52); send_file();
      add_header(); add_fmt(16, 1, 1, 8000, 16); add_chunk(TAG_DATA, 4);
      wav_bytes = wav_bytes[0:MIN_FILE_BYTES - 2]; send_file();
      // Exactly the minimum length, with an empty data chunk.
      add_header(); add_fmt(16, 1, 2, 44100, 16); add_chunk(TAG_DATA, 0); send_file();
      // Broken RIFF tag, broken WAVE tag.
      add_header(); add_fmt(16, 1, 1, 8000, 16); add_chunk(TAG_DATA, 8);
      wav_bytes[3] ^= 8'h01; send_file();
      add_header(); add_fmt(16, 1, 1, 8000, 16); add_chunk(TAG_DATA, 8);
      wav_bytes[11] ^= 8'h80; send_file();
      // Format faults, one each.
      add_header(); add_chunk("junk", 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 3, 1, 8000, 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 16'h0101, 1, 8000, 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 1, 1, 0, 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 1, 0, 8000, 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 1, 3, 8000, 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 1, 16'h0101, 8000, 16); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 1, 1, 8000, 8); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(16, 1, 1, 8000, 16'h0110); add_chunk(TAG_DATA, 8); send_file();
      add_header(); add_fmt(15, 1, 1, 8000, 16); add_chunk(TAG_DATA, 20); send_file();
      add_header(); add_fmt(0, 1, 1, 8000, 16); add_chunk(TAG_DATA, 30); send_file();
      // A later fmt chunk replaces an earlier one, both ways round.
      add_header(); add_fmt(16, 3, 1, 8000, 16); add_fmt(16, 1, 2, 22050, 16);
      add_chunk(TAG_DATA, 6); send_file();
      add_header(); add_fmt(16, 1, 2, 22050, 16); add_chunk(TAG_DATA, 6);
      add_fmt(16, 1, 1, 22050, 24); send_file();
      // A later empty data chunk wins over a non-empty one.
      add_header(); add_fmt(16, 1, 1, 8000, 16); add_chunk(TAG_DATA, 6);
      add_chunk(TAG_DATA, 0); send_file();
      // File ends inside a huge data chunk; the earlier data chunk stands.
      add_header(); add_fmt(16, 1, 1, 8000, 16); add_chunk(TAG_DATA, 10);
      add_chunk_head(TAG_DATA, 32'hFFFF_FFFF); repeat (3) wav_bytes.push_back($urandom);
      send_file();
      // Data chunk ahead of the fmt chunk.
      add_header(); add_chunk(TAG_DATA, 9); add_fmt(16, 1, 2, 96000, 16); send_file();
      wait_drained();

      first_bytes = bytes_sent;
      first_files = files_sent;
      while (bytes_sent - first_bytes < RANDOM_BYTES || files_sent - first_files < RANDOM_FILES)
      begin
         calm = (files_sent - first_files >= 2 && files_sent - first_files < 6);
         if (files_sent - first_files == 6) begin
            // Results back up behind a stalled receiver until input is refused.
            hold_request = 1'b1;
            repeat (8) begin
               repeat ($urandom_range(1, 2)) wav_bytes.push_back($urandom);
               send_file();
            end
            wait_drained();
         end
         random_file();
         send_file();
      end
      calm = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (summary_board.mismatch_count == 0 &&
          summary_board.expected_summaries.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/wrhp_pkg.sv
rtl/wrhp_byte_stage.sv
rtl/wrhp_parser.sv
rtl/wrhp_rsp_reg.sv
rtl/wav_riff_header_parser.sv
bench/tb.sv
